FILE: hdl/fwrl_pkg.sv
package fwrl_pkg;

  localparam int MaxClients = 64;
  localparam int IdxW = (MaxClients > 1) ? $clog2(MaxClients) : 1;
  localparam int CntW = $clog2(MaxClients + 1);
  localparam int KeyW = 16;
  localparam int TimeW = 48;
  localparam int QW = 31;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
  localparam logic [QW-1:0] GlobalLimitRst = QW'(1000);
  localparam logic [QW-1:0] GlobalWinRst = QW'(1000);

  typedef enum logic [2:0] {
    MODE_CHECK_COUNT = 3'd0,
    MODE_CHECK_ONLY  = 3'd1,
    MODE_SET_CLIENT  = 3'd2,
    MODE_REMOVE      = 3'd3,
    MODE_RESET       = 3'd4,
    MODE_QUERY       = 3'd5,
    MODE_PURGE       = 3'd6,
    MODE_NONE        = 3'd7
  } mode_e;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusNotFound = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;

  localparam logic CfgGlobalLimit = 1'b0;
  localparam logic CfgGlobalWin = 1'b1;

  typedef struct packed {
    logic [2:0]       mode;
    logic [TimeW-1:0] now_ms;
    logic [KeyW-1:0]  client_key;
    logic [QW-1:0]    client_quota;
    logic [QW-1:0]    client_window_len;
    logic [QW-1:0]    idle_limit_ms;
  } in_item_t;

  typedef struct packed {
    logic             allowed;
    logic [1:0]       status;
    logic [QW-1:0]    remaining;
    logic [TimeW-1:0] window_end;
    logic [6:0]       removed_count;
    logic [TimeW-1:0] total_seen;
    logic [TimeW-1:0] allowed_seen;
    logic [TimeW-1:0] rejected_seen;
    logic [TimeW-1:0] clients_added;
  } out_item_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [QW-1:0]    quota;
    logic [QW-1:0]    wlen;
    logic [QW-1:0]    used;
    logic [TimeW-1:0] wend;
    logic [TimeW-1:0] last;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  function automatic logic [TimeW-1:0] end_at(logic [TimeW-1:0] now, logic [QW-1:0] len);
    logic [TimeW:0] s;
    s = {1'b0, now} + {{(TimeW + 1 - QW){1'b0}}, len};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

  function automatic logic [TimeW-1:0] sat_inc(logic [TimeW-1:0] v);
    return (v == TimeMax) ? v : v + TimeW'(1);
  endfunction

endpackage

FILE: hdl/fwrl_ram.sv
module fwrl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/fixed_window_rate_limiter.sv
// Flow: an accepted item scans every entry through the registered entry RAM read port
// (purge drops idle entries here), then an execute state writes back at most one entry, then
// a write state loads the result register and raises out_valid, holding while the output stalls.
// A new item is accepted only in the idle state, after the previous item has left the write state.
// A result waiting in the output register does not block the next item's scan.
// Reset clears valid bits, global window, statistics and config to defaults.
module fixed_window_rate_limiter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fwrl_pkg::in_item_t            in_data_i,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fwrl_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index_i,
  input  logic [fwrl_pkg::QW-1:0]       cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_WRITE = 4'b1000
  } state_e;

  localparam int IdxW = fwrl_pkg::IdxW;
  localparam int TimeW = fwrl_pkg::TimeW;
  localparam int QW = fwrl_pkg::QW;

  state_e state_q, state_d;
  fwrl_pkg::in_item_t item_q;
  logic [fwrl_pkg::MaxClients-1:0] valid_q;
  logic [IdxW:0] scan_q;
  logic [IdxW-1:0] raddr;
  logic rd_pend_q;
  logic [IdxW-1:0] rd_idx_q;
  fwrl_pkg::entry_t rdata, hit_q, wdata;
  logic hit_found_q;
  logic [IdxW-1:0] hit_idx_q;
  logic [6:0] removed_q;
  logic we;
  logic [IdxW-1:0] waddr;

  logic [QW-1:0] glimit_q, gwin_q, gused_q;
  logic [TimeW-1:0] gend_q, st_tot_q, st_all_q, st_rej_q, st_cli_q;

  logic out_valid_q;
  fwrl_pkg::out_item_t out_q;

  logic free_found;
  logic [IdxW-1:0] free_idx;

  fwrl_ram #(.Width(fwrl_pkg::EntryW), .Depth(fwrl_pkg::MaxClients)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign raddr = scan_q[IdxW-1:0];
  assign in_stall = (state_q != ST_IDLE);
  assign out_valid = out_valid_q;
  assign out_data_o = out_q;
  assign cfg_ready = 1'b1;

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = fwrl_pkg::MaxClients - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  logic purge_hit;
  logic [TimeW-1:0] idle_gap;
  assign idle_gap = item_q.now_ms - rdata.last;
  assign purge_hit = rd_pend_q && valid_q[rd_idx_q] && (item_q.now_ms > rdata.last) &&
                     (idle_gap > {{(TimeW - QW){1'b0}}, item_q.idle_limit_ms});

  // execution of one item
  logic ex_we;
  fwrl_pkg::entry_t ex_e;
  logic ex_allowed;
  logic [1:0] ex_status;
  logic [QW-1:0] ex_rem, gused_d;
  logic [TimeW-1:0] ex_wend, gend_d, tot_d, all_d, rej_d, cli_d;
  logic ex_set_valid, ex_clr_valid;
  logic [IdxW-1:0] ex_idx;
  logic [TimeW-1:0] nowv;

  always_comb begin
    fwrl_pkg::entry_t e;
    logic cnt;
    e = hit_q;
    nowv = item_q.now_ms;
    cnt = (item_q.mode == fwrl_pkg::MODE_CHECK_COUNT);
    ex_we = 1'b0;
    ex_allowed = 1'b0;
    ex_status = fwrl_pkg::StatusOk;
    ex_rem = '0;
    ex_wend = '0;
    ex_set_valid = 1'b0;
    ex_clr_valid = 1'b0;
    ex_idx = hit_idx_q;
    gused_d = gused_q;
    gend_d = gend_q;
    tot_d = st_tot_q;
    all_d = st_all_q;
    rej_d = st_rej_q;
    cli_d = st_cli_q;
    case (fwrl_pkg::mode_e'(item_q.mode))
      fwrl_pkg::MODE_CHECK_COUNT, fwrl_pkg::MODE_CHECK_ONLY: begin
        if (!hit_found_q) ex_status = fwrl_pkg::StatusNotFound;
        if (nowv >= gend_q) begin
          gused_d = '0;
          gend_d = fwrl_pkg::end_at(nowv, gwin_q);
        end
        if (gused_d >= glimit_q) begin
          rej_d = fwrl_pkg::sat_inc(st_rej_q);
          if (cnt) tot_d = fwrl_pkg::sat_inc(st_tot_q);
        end else if (hit_found_q) begin
          if (nowv >= e.wend) begin
            e.used = '0;
            e.wend = fwrl_pkg::end_at(nowv, e.wlen);
            ex_we = 1'b1;
          end
          if (e.used >= e.quota) begin
            if (cnt) begin
              rej_d = fwrl_pkg::sat_inc(st_rej_q);
              tot_d = fwrl_pkg::sat_inc(st_tot_q);
            end
          end else begin
            ex_allowed = 1'b1;
            if (cnt) begin
              e.used = e.used + QW'(1);
              e.last = nowv;
              ex_we = 1'b1;
              gused_d = gused_d + QW'(1);
              all_d = fwrl_pkg::sat_inc(st_all_q);
              tot_d = fwrl_pkg::sat_inc(st_tot_q);
            end
          end
        end else begin
          ex_allowed = 1'b1;
          if (cnt) begin
            gused_d = gused_d + QW'(1);
            all_d = fwrl_pkg::sat_inc(st_all_q);
            tot_d = fwrl_pkg::sat_inc(st_tot_q);
          end
        end
      end
      fwrl_pkg::MODE_SET_CLIENT: begin
        if (!hit_found_q) begin
          if (!free_found) begin
            ex_status = fwrl_pkg::StatusFull;
          end else begin
            ex_idx = free_idx;
            ex_set_valid = 1'b1;
            e.key = item_q.client_key;
            e.last = nowv;
            cli_d = fwrl_pkg::sat_inc(st_cli_q);
          end
        end
        if (hit_found_q || free_found) begin
          ex_we = 1'b1;
          e.quota = item_q.client_quota;
          e.wlen = item_q.client_window_len;
          e.used = '0;
          e.wend = fwrl_pkg::end_at(nowv, item_q.client_window_len);
        end
      end
      fwrl_pkg::MODE_REMOVE: begin
        if (!hit_found_q) ex_status = fwrl_pkg::StatusNotFound;
        else ex_clr_valid = 1'b1;
      end
      fwrl_pkg::MODE_RESET: begin
        if (!hit_found_q) begin
          ex_status = fwrl_pkg::StatusNotFound;
        end else begin
          ex_we = 1'b1;
          e.used = '0;
          e.wend = fwrl_pkg::end_at(nowv, e.wlen);
        end
      end
      fwrl_pkg::MODE_QUERY: begin
        if (!hit_found_q) begin
          ex_status = fwrl_pkg::StatusNotFound;
          ex_rem = glimit_q;
          ex_wend = gend_q;
        end else begin
          ex_wend = e.wend;
          if (nowv >= e.wend) ex_rem = e.quota;
          else if (e.quota > e.used) ex_rem = e.quota - e.used;
        end
      end
      default: begin
      end
    endcase
    ex_e = e;
  end

  assign we = (state_q == ST_EXEC) && ex_we;
  assign waddr = ex_idx;
  assign wdata = ex_e;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid && !in_stall) state_d = ST_SCAN;
      ST_SCAN:  if (scan_q == (IdxW + 1)'(fwrl_pkg::MaxClients) && !rd_pend_q) state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_WRITE;
      ST_WRITE: if (!(out_valid_q && out_stall)) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  logic [QW-1:0] gused_r;
  logic [TimeW-1:0] gend_r, tot_r, all_r, rej_r, cli_r;
  logic ex_allowed_r, set_r, clr_r;
  logic [1:0] status_r;
  logic [QW-1:0] rem_r;
  logic [TimeW-1:0] wend_r;
  logic [IdxW-1:0] idx_r;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) item_q <= in_data_i;
    if (rd_pend_q && valid_q[rd_idx_q] && rdata.key == item_q.client_key && !hit_found_q)
      hit_q <= rdata;
    if (state_q == ST_EXEC) begin
      ex_allowed_r <= ex_allowed;
      status_r <= ex_status;
      rem_r <= ex_rem;
      wend_r <= ex_wend;
      idx_r <= ex_idx;
      set_r <= ex_set_valid;
      clr_r <= ex_clr_valid;
      gused_r <= gused_d;
      gend_r <= gend_d;
      tot_r <= tot_d;
      all_r <= all_d;
      rej_r <= rej_d;
      cli_r <= cli_d;
    end
    if (state_q == ST_WRITE && !(out_valid_q && out_stall)) begin
      out_q.allowed <= ex_allowed_r;
      out_q.status <= status_r;
      out_q.remaining <= rem_r;
      out_q.window_end <= wend_r;
      out_q.removed_count <= removed_q;
      out_q.total_seen <= tot_r;
      out_q.allowed_seen <= all_r;
      out_q.rejected_seen <= rej_r;
      out_q.clients_added <= cli_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      scan_q <= '0;
      rd_pend_q <= 1'b0;
      rd_idx_q <= '0;
      hit_found_q <= 1'b0;
      hit_idx_q <= '0;
      removed_q <= '0;
      glimit_q <= fwrl_pkg::GlobalLimitRst;
      gwin_q <= fwrl_pkg::GlobalWinRst;
      gused_q <= '0;
      gend_q <= '0;
      st_tot_q <= '0;
      st_all_q <= '0;
      st_rej_q <= '0;
      st_cli_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index_i == fwrl_pkg::CfgGlobalLimit) glimit_q <= cfg_data_i;
        else gwin_q <= cfg_data_i;
      end
      if (out_valid_q && !out_stall && state_q != ST_WRITE) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          scan_q <= '0;
          rd_pend_q <= 1'b0;
          hit_found_q <= 1'b0;
          removed_q <= '0;
        end
        ST_SCAN: begin
          if (scan_q != (IdxW + 1)'(fwrl_pkg::MaxClients)) begin
            rd_pend_q <= 1'b1;
            rd_idx_q <= raddr;
            scan_q <= scan_q + (IdxW + 1)'(1);
          end else begin
            rd_pend_q <= 1'b0;
          end
          if (rd_pend_q) begin
            if (valid_q[rd_idx_q] && rdata.key == item_q.client_key && !hit_found_q) begin
              hit_found_q <= 1'b1;
              hit_idx_q <= rd_idx_q;
            end
            if (item_q.mode == fwrl_pkg::MODE_PURGE && purge_hit) begin
              valid_q[rd_idx_q] <= 1'b0;
              if (removed_q != 7'h7f) removed_q <= removed_q + 7'd1;
            end
          end
        end
        ST_WRITE: begin
          if (!(out_valid_q && out_stall)) begin
            if (set_r) valid_q[idx_r] <= 1'b1;
            if (clr_r) valid_q[idx_r] <= 1'b0;
            gused_q <= gused_r;
            gend_q <= gend_r;
            st_tot_q <= tot_r;
            st_all_q <= all_r;
            st_rej_q <= rej_r;
            st_cli_q <= cli_r;
            out_valid_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall) else $error("accept while busy");
  a_write_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == ST_EXEC)) else $error("ram write outside exec");
  a_out_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_WRITE) else $error("stray result");

endmodule

FILE: verif/fixed_window_rate_limiter_tb.sv
`timescale 1ns / 1ps

module fixed_window_rate_limiter_tb;

  localparam int WatchdogLimit = 5000;
  localparam int MaxClients = fwrl_pkg::MaxClients;
  localparam int KeyW = fwrl_pkg::KeyW;
  localparam int QW = fwrl_pkg::QW;
  localparam int TimeW = fwrl_pkg::TimeW;
  localparam int DrainCycles = 2 * (MaxClients + 3) + 20;
  localparam logic [63:0] M48 = 64'hFFFF_FFFF_FFFF;
  localparam logic [30:0] Q31Max = 31'h7FFF_FFFF;

  class limiter_scoreboard;
    fwrl_pkg::out_item_t pending[$];
    int errors;
    bit e_vld[MaxClients];
    logic [KeyW-1:0] e_key[MaxClients];
    logic [63:0] e_quota[MaxClients], e_wlen[MaxClients], e_used[MaxClients];
    logic [63:0] e_wend[MaxClients], e_last[MaxClients];
    logic [63:0] g_used, g_end, n_total, n_allowed, n_rejected, n_clients;
    logic [63:0] g_limit, g_wlen;

    function new();
      foreach (e_vld[i]) e_vld[i] = 1'b0;
      g_used = 0; g_end = 0; n_total = 0; n_allowed = 0; n_rejected = 0; n_clients = 0;
      g_limit = 1000; g_wlen = 1000; errors = 0;
    endfunction

    function logic [63:0] bump(logic [63:0] v);
      return (v < M48) ? v + 1 : M48;
    endfunction

    function logic [63:0] window_end_at(logic [63:0] now, logic [63:0] len);
      return (now + len > M48) ? M48 : now + len;
    endfunction

    function int lookup(logic [KeyW-1:0] k);
      for (int i = 0; i < MaxClients; i++) if (e_vld[i] && e_key[i] == k) return i;
      return -1;
    endfunction

    function void write_cfg(logic idx, logic [QW-1:0] v);
      if (idx == fwrl_pkg::CfgGlobalLimit) g_limit = v;
      else g_wlen = v;
    endfunction

    function void note(fwrl_pkg::in_item_t it);
      logic [63:0] now, idl;
      logic [KeyW-1:0] k;
      int idx;
      bit counting;
      fwrl_pkg::out_item_t r;
      now = it.now_ms; idl = it.idle_limit_ms; k = it.client_key;
      r = '0;
      idx = lookup(k);
      case (it.mode)
        fwrl_pkg::MODE_CHECK_COUNT, fwrl_pkg::MODE_CHECK_ONLY: begin
          counting = (it.mode == fwrl_pkg::MODE_CHECK_COUNT);
          if (idx < 0) r.status = fwrl_pkg::StatusNotFound;
          if (now >= g_end) begin
            g_used = 0;
            g_end = window_end_at(now, g_wlen);
          end
          if (g_used >= g_limit) begin
            n_rejected = bump(n_rejected);
            if (counting) n_total = bump(n_total);
          end else if (idx >= 0) begin
            if (now >= e_wend[idx]) begin
              e_used[idx] = 0;
              e_wend[idx] = window_end_at(now, e_wlen[idx]);
            end
            if (e_used[idx] >= e_quota[idx]) begin
              if (counting) begin
                n_rejected = bump(n_rejected);
                n_total = bump(n_total);
              end
            end else begin
              r.allowed = 1'b1;
              if (counting) begin
                e_used[idx]++;
                e_last[idx] = now;
                g_used++;
                n_allowed = bump(n_allowed);
                n_total = bump(n_total);
              end
            end
          end else begin
            r.allowed = 1'b1;
            if (counting) begin
              g_used++;
              n_allowed = bump(n_allowed);
              n_total = bump(n_total);
            end
          end
        end
        fwrl_pkg::MODE_SET_CLIENT: begin
          if (idx < 0) begin
            for (int i = 0; i < MaxClients; i++)
              if (!e_vld[i] && idx < 0) idx = i;
            if (idx < 0) r.status = fwrl_pkg::StatusFull;
            else begin
              e_vld[idx] = 1'b1;
              e_key[idx] = k;
              e_last[idx] = now;
              n_clients = bump(n_clients);
            end
          end
          if (idx >= 0) begin
            e_quota[idx] = it.client_quota;
            e_wlen[idx] = it.client_window_len;
            e_used[idx] = 0;
            e_wend[idx] = window_end_at(now, it.client_window_len);
          end
        end
        fwrl_pkg::MODE_REMOVE: begin
          if (idx < 0) r.status = fwrl_pkg::StatusNotFound;
          else e_vld[idx] = 1'b0;
        end
        fwrl_pkg::MODE_RESET: begin
          if (idx < 0) r.status = fwrl_pkg::StatusNotFound;
          else begin
            e_used[idx] = 0;
            e_wend[idx] = window_end_at(now, e_wlen[idx]);
          end
        end
        fwrl_pkg::MODE_QUERY: begin
          if (idx < 0) begin
            r.status = fwrl_pkg::StatusNotFound;
            r.remaining = g_limit[QW-1:0];
            r.window_end = g_end[TimeW-1:0];
          end else begin
            r.window_end = e_wend[idx][TimeW-1:0];
            if (now >= e_wend[idx]) r.remaining = e_quota[idx][QW-1:0];
            else if (e_quota[idx] > e_used[idx])
              r.remaining = QW'(e_quota[idx] - e_used[idx]);
          end
        end
        fwrl_pkg::MODE_PURGE: begin
          for (int i = 0; i < MaxClients; i++)
            if (e_vld[i] && now > e_last[i] && now - e_last[i] > idl) begin
              e_vld[i] = 1'b0;
              if (r.removed_count < 127) r.removed_count++;
            end
        end
        default: ;
      endcase
      r.total_seen = n_total[TimeW-1:0];
      r.allowed_seen = n_allowed[TimeW-1:0];
      r.rejected_seen = n_rejected[TimeW-1:0];
      r.clients_added = n_clients[TimeW-1:0];
      pending.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check(fwrl_pkg::out_item_t got);
      fwrl_pkg::out_item_t w;
      if (pending.size() == 0) begin
        report("unexpected beat", 0, 0);
        return;
      end
      w = pending.pop_front();
      if (got.allowed !== w.allowed) report("allowed", got.allowed, w.allowed);
      if (got.status !== w.status) report("status", got.status, w.status);
      if (got.remaining !== w.remaining) report("remaining", got.remaining, w.remaining);
      if (got.window_end !== w.window_end) report("window_end", got.window_end, w.window_end);
      if (got.removed_count !== w.removed_count)
        report("removed_count", got.removed_count, w.removed_count);
      if (got.total_seen !== w.total_seen) report("total_seen", got.total_seen, w.total_seen);
      if (got.allowed_seen !== w.allowed_seen)
        report("allowed_seen", got.allowed_seen, w.allowed_seen);
      if (got.rejected_seen !== w.rejected_seen)
        report("rejected_seen", got.rejected_seen, w.rejected_seen);
      if (got.clients_added !== w.clients_added)
        report("clients_added", got.clients_added, w.clients_added);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fwrl_pkg::in_item_t in_data_i = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fwrl_pkg::out_item_t out_data_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index_i = 1'b0;
  logic [QW-1:0] cfg_data_i = '0;

  limiter_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit long_hold = 1'b0;
  int hold_cnt = 0;
  int quiet_cnt = 0;
  int beats_in = 0;
  int beats_out = 0;
  int key_pool = 16;
  int set_weight = 15;
  logic [63:0] now_t = 0;

  always #5 clk_i = ~clk_i;

  fixed_window_rate_limiter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data_i  (in_data_i),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data_o (out_data_o),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      sb.check(out_data_o);
      beats_out++;
    end
    if (long_hold) begin
      out_stall <= 1'b1;
      hold_cnt++;
      if (hold_cnt >= 600) begin
        long_hold = 1'b0;
        hold_cnt = 0;
      end
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cnt = 0;
    else if (rst_ni)
      quiet_cnt++;
    if (quiet_cnt >= WatchdogLimit) begin
      $display("watchdog: no beat for %0d cycles", WatchdogLimit);
      $display("fixed_window_rate_limiter_tb NOT OK");
      $finish;
    end
  end

  task send_beat(fwrl_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall);
    sb.note(it);
    beats_in++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task drain;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task write_reg(logic idx, logic [QW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_cfg(idx, v);
  endtask

  task set_limits(logic [QW-1:0] lim, logic [QW-1:0] wl);
    drain();
    write_reg(fwrl_pkg::CfgGlobalLimit, lim);
    write_reg(fwrl_pkg::CfgGlobalWin, wl);
    cfg_valid <= 1'b0;
  endtask

  function fwrl_pkg::in_item_t mk(fwrl_pkg::mode_e m, logic [63:0] now, logic [KeyW-1:0] k,
                                  logic [QW-1:0] q, logic [QW-1:0] wl, logic [QW-1:0] idl);
    fwrl_pkg::in_item_t it;
    it.mode = m; it.now_ms = now[TimeW-1:0]; it.client_key = k;
    it.client_quota = q; it.client_window_len = wl; it.idle_limit_ms = idl;
    return it;
  endfunction

  function fwrl_pkg::in_item_t rand_item();
    fwrl_pkg::in_item_t it;
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) it.mode = fwrl_pkg::MODE_CHECK_COUNT;
    else if (pick < 50) it.mode = fwrl_pkg::MODE_CHECK_ONLY;
    else if (pick < 50 + set_weight) it.mode = fwrl_pkg::MODE_SET_CLIENT;
    else if (pick < 70) it.mode = fwrl_pkg::MODE_QUERY;
    else if (pick < 80) it.mode = fwrl_pkg::MODE_REMOVE;
    else if (pick < 88) it.mode = fwrl_pkg::MODE_RESET;
    else if (pick < 96) it.mode = fwrl_pkg::MODE_PURGE;
    else it.mode = fwrl_pkg::MODE_NONE;
    if ($urandom_range(99) < 90) now_t += $urandom_range(0, 4);
    else now_t += $urandom_range(0, 3000);
    if (now_t > M48) now_t = 0;
    it.now_ms = ($urandom_range(99) < 3) ? TimeW'({$urandom, $urandom}) : now_t[TimeW-1:0];
    it.client_key = ($urandom_range(99) < 6) ? KeyW'($urandom) :
                    KeyW'($urandom_range(0, key_pool - 1));
    it.client_quota = ($urandom_range(99) < 8) ? QW'($urandom) : QW'($urandom_range(0, 8));
    it.client_window_len = ($urandom_range(99) < 8) ? QW'($urandom) :
                           QW'($urandom_range(0, 400));
    it.idle_limit_ms = ($urandom_range(99) < 8) ? QW'($urandom) : QW'($urandom_range(0, 500));
    return it;
  endfunction

  task random_run(int n);
    for (int i = 0; i < n; i++) send_beat(rand_item());
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(mk(fwrl_pkg::MODE_CHECK_COUNT, 0, 16'h0000, 0, 0, 0));
    send_beat(mk(fwrl_pkg::MODE_QUERY, 5, 16'h1234, 0, 0, 0));
    send_beat(mk(fwrl_pkg::MODE_SET_CLIENT, 10, 16'hFFFF, 0, 0, 0));
    send_beat(mk(fwrl_pkg::MODE_CHECK_COUNT, 11, 16'hFFFF, 0, 0, 0));
    send_beat(mk(fwrl_pkg::MODE_CHECK_ONLY, 12, 16'hFFFF, 0, 0, 0));
    send_beat(mk(fwrl_pkg::MODE_SET_CLIENT, 20, 16'h0001, 2, 100, 0));
    send_beat(mk(fwrl_pkg::MODE_CHECK_COUNT, 21, 16'h0001, 0, 0, 0));
    send_beat(mk(fwrl_pkg::MODE_CHECK_COUNT, 22, 16'h0001, 0, 0, 0));
    send_beat(mk(fwrl_pkg::MODE_CHECK_COUNT, 23, 16'h0001, 0, 0, 0));
    send_beat(mk(fwrl_pkg::MODE_CHECK_ONLY, 24, 16'h0001, 0, 0, 0));
    send_beat(mk(fwrl_pkg::MODE_QUERY, 25, 16'h0001, 0, 0, 0));
    send_beat(mk(fwrl_pkg::MODE_SET_CLIENT, 26, 16'h0001, 5, 50, 0));
    send_beat(mk(fwrl_pkg::MODE_RESET, 30, 16'h0001, 0, 0, 0));
    send_beat(mk(fwrl_pkg::MODE_QUERY, 500, 16'h0001, 0, 0, 0));
    send_beat(mk(fwrl_pkg::MODE_RESET, 31, 16'h7777, 0, 0, 0));
    send_beat(mk(fwrl_pkg::MODE_REMOVE, 32, 16'h0001, 0, 0, 0));
    send_beat(mk(fwrl_pkg::MODE_REMOVE, 33, 16'h0001, 0, 0, 0));
    send_beat(mk(fwrl_pkg::MODE_SET_CLIENT, M48 - 5, 16'h0002, Q31Max, Q31Max, 0));
    send_beat(mk(fwrl_pkg::MODE_CHECK_COUNT, M48, 16'h0002, 0, 0, 0));
    send_beat(mk(fwrl_pkg::MODE_QUERY, M48, 16'h0002, 0, 0, 0));
    send_beat(mk(fwrl_pkg::MODE_PURGE, 0, 16'h0000, 0, 0, Q31Max));
    send_beat(mk(fwrl_pkg::MODE_PURGE, M48, 16'h0000, 0, 0, 0));
    send_beat(mk(fwrl_pkg::MODE_NONE, 40, 16'h0003, Q31Max, Q31Max, Q31Max));
    random_run(200);

    set_limits(5, 50);
    tx_idle_pct = 81;
    random_run(300);

    set_limits(0, 0);
    tx_idle_pct = 0;
    rx_stall_pct = 81;
    long_hold = 1'b1;
    random_run(300);

    set_limits(Q31Max, Q31Max);
    tx_idle_pct = 28;
    rx_stall_pct = 28;
    random_run(300);

    set_limits(3, 10);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    key_pool = 90;
    set_weight = 35;
    random_run(400);

    set_limits(20, 200);
    tx_idle_pct = 81;
    key_pool = 16;
    set_weight = 15;
    random_run(330);

    drain();
    $display("covered %0d input beats and %0d result beats over six limit settings,", beats_in,
             beats_out);
    $display("including zero and full-range limits, a full client table and long output stalls");
    if (sb.errors == 0) begin
      $display("fixed_window_rate_limiter_tb OK");
    end else begin
      $display("fixed_window_rate_limiter_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/fwrl_pkg.sv
hdl/fwrl_ram.sv
hdl/fixed_window_rate_limiter.sv
verif/fixed_window_rate_limiter_tb.sv
